FILE: rtl/cpfv_pkg.sv
// Package for the CPF check-digit validator: digit vector types, status codes
// and fixed constants of the CPF format.
// No dependencies.
package cpfv_pkg;

  // Input width and the eleven decimal digits of a CPF number
  localparam int unsigned InW       = 37;
  localparam int unsigned NumDigits = 11;

  // Largest CPF number that is accepted
  localparam logic [InW-1:0] CpfMax = InW'(64'd99999999999);

  // Result codes
  typedef enum logic [1:0] {
    ST_VALID  = 2'd0,
    ST_RANGE  = 2'd1,
    ST_FIRST  = 2'd2,
    ST_SECOND = 2'd3
  } status_e;

  // BCD digit vector, element NumDigits-1 is the most significant digit
  typedef logic [NumDigits-1:0][3:0] bcd_t;

  // Payload that travels through the binary to BCD stages
  typedef struct packed {
    logic bad;   // zero or out of range
    bcd_t bcd;
  } dab_t;

endpackage

FILE: rtl/cpfv_dabble_stage.sv
// One register stage of the pipelined binary to BCD converter (shift and
// add-3), consuming Steps bits of the binary word per stage.
// Depends on cpfv_pkg.
module cpfv_dabble_stage #(
  parameter int unsigned Steps = 4,
  parameter int unsigned BinW  = 40
) (
  input  logic               clk_i,
  input  logic               load_i,
  input  logic [BinW-1:0]    bin_i,
  input  cpfv_pkg::dab_t     dab_i,
  output logic [BinW-1:0]    bin_o,
  output cpfv_pkg::dab_t     dab_o
);
  import cpfv_pkg::*;

  logic [BinW-1:0] bin_d, bin_q;
  dab_t            dab_d, dab_q;

  // Steps iterations of add-3 then shift, each digit corrected on its own
  always_comb begin
    bin_d = bin_i;
    dab_d = dab_i;
    for (int unsigned s = 0; s < Steps; s++) begin
      for (int unsigned k = 0; k < NumDigits; k++) begin
        if (dab_d.bcd[k] >= 4'd5) begin
          dab_d.bcd[k] = dab_d.bcd[k] + 4'd3;
        end
      end
      // BCD vector moves up one bit, binary MSB enters at the bottom
      dab_d.bcd = (4*NumDigits)'({dab_d.bcd, bin_d[BinW-1]});
      bin_d     = {bin_d[BinW-2:0], 1'b0};
    end
  end

  // Payload register, no reset needed
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      bin_q <= bin_d;
      dab_q <= dab_d;
    end
  end

  assign bin_o = bin_q;
  assign dab_o = dab_q;

endmodule

FILE: rtl/cpf_check_digit_validator_unit.sv
// Top level of the CPF check-digit validator: range check, pipelined binary
// to BCD conversion, weighted sums, mod 11 check digits and result compare.
// Depends on cpfv_pkg and cpfv_dabble_stage.
//
//   channel  signals                          direction  meaning
//   in       in_valid_i/in_ready_o,           sink       one CPF number
//            cpf_number_i[36:0]
//   out      out_valid_o/out_ready_i,         source     verdict per number
//            is_valid_o, status_o[1:0]
//
// One number enters per cycle while the pipeline is not stalled; each number
// passes through the input register, the BCD conversion stages, the sum
// stage, the mod 11 stage and the output register.
// Reset clears only the stage valid bits; payload registers are not reset.
// Each stage holds its data while the next one is full and stalled, so a
// stalled output blocks the input only once every stage holds a transfer.
module cpf_check_digit_validator_unit #(
  parameter int unsigned BitsPerStage = 4   // 1 to 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [cpfv_pkg::InW-1:0] cpf_number_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic                     is_valid_o,
  output logic [1:0]               status_o
);
  import cpfv_pkg::*;

  localparam int unsigned NumStages = (InW + BitsPerStage - 1) / BitsPerStage;
  localparam int unsigned BinW      = NumStages * BitsPerStage;
  localparam int unsigned SumIdx    = NumStages + 1;
  localparam int unsigned ModIdx    = NumStages + 2;
  localparam int unsigned Last      = NumStages + 3;

  // Turn a weighted sum into its check digit: (10*s) mod 11, 10 becomes 0.
  // 10*s mod 11 equals (11 - s mod 11) mod 11.
  function automatic logic [3:0] check_digit_f(input logic [9:0] s);
    logic [17:0] prod;
    logic [6:0]  quot;
    logic [10:0] rem_w;
    logic [4:0]  rem;
    begin
      prod  = 18'(s) * 18'd186;          // 186/2048 slightly under 1/11
      quot  = prod[17:11];
      rem_w = 11'(s) - 11'(({4'd0, quot} << 3) + ({4'd0, quot} << 1) + 11'(quot));
      rem   = rem_w[4:0];
      if (rem >= 5'd11) begin
        rem = rem - 5'd11;
      end
      if (rem <= 5'd1) begin
        check_digit_f = 4'd0;
      end else begin
        check_digit_f = 4'(5'd11 - rem);
      end
    end
  endfunction

  // ---------------------------------------------------------------------
  // Stage valid bits and advance enables
  // ---------------------------------------------------------------------
  logic [Last:0] v_q, v_d, adv;

  // A stage may take new data when the output is ready or when it or any stage downstream is empty
  for (genvar k = 0; k <= Last; k++) begin : g_adv
    assign adv[k] = out_ready_i | ~(&v_q[Last:k]);
  end

  always_comb begin
    v_d[0] = adv[0] ? in_valid_i : v_q[0];
    for (int unsigned k = 1; k <= Last; k++) begin
      v_d[k] = adv[k] ? v_q[k-1] : v_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign in_ready_o  = adv[0];
  assign out_valid_o = v_q[Last];

  // ---------------------------------------------------------------------
  // Input stage: register the number and flag zero or out of range
  // ---------------------------------------------------------------------
  logic [BinW-1:0] bin_w [NumStages+1];
  dab_t            dab_w [NumStages+1];
  logic [BinW-1:0] bin0_q;
  dab_t            dab0_q;

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      bin0_q     <= BinW'(cpf_number_i);
      dab0_q.bad <= (cpf_number_i == '0) || (cpf_number_i > CpfMax);
      dab0_q.bcd <= '0;
    end
  end

  assign bin_w[0] = bin0_q;
  assign dab_w[0] = dab0_q;

  // ---------------------------------------------------------------------
  // Binary to BCD conversion stages
  // ---------------------------------------------------------------------
  for (genvar i = 0; i < NumStages; i++) begin : g_dab
    cpfv_dabble_stage #(
      .Steps (BitsPerStage),
      .BinW  (BinW)
    ) u_stage (
      .clk_i  (clk_i),
      .load_i (adv[i+1]),
      .bin_i  (bin_w[i]),
      .dab_i  (dab_w[i]),
      .bin_o  (bin_w[i+1]),
      .dab_o  (dab_w[i+1])
    );
  end

  // ---------------------------------------------------------------------
  // Sum stage: weighted digit sums for both check digits
  // ---------------------------------------------------------------------
  bcd_t       digits;
  logic [9:0] sum1_d, sum2_d;
  logic [9:0] sum1_q, sum2_q;
  logic [3:0] s_d9_q, s_d10_q;
  logic       s_bad_q;

  assign digits = dab_w[NumStages].bcd;

  // digit n (most significant first) sits at index NumDigits-1-n
  always_comb begin
    sum1_d = '0;
    sum2_d = '0;
    for (int unsigned n = 0; n < 9; n++) begin
      sum1_d = sum1_d + 10'(digits[NumDigits-1-n]) * 10'(10 - n);
    end
    for (int unsigned n = 0; n < 10; n++) begin
      sum2_d = sum2_d + 10'(digits[NumDigits-1-n]) * 10'(11 - n);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[SumIdx]) begin
      sum1_q  <= sum1_d;
      sum2_q  <= sum2_d;
      s_d9_q  <= digits[1];
      s_d10_q <= digits[0];
      s_bad_q <= dab_w[NumStages].bad;
    end
  end

  // ---------------------------------------------------------------------
  // Mod 11 stage: expected check digits
  // ---------------------------------------------------------------------
  logic [3:0] cd1_q, cd2_q, m_d9_q, m_d10_q;
  logic       m_bad_q;

  always_ff @(posedge clk_i) begin
    if (adv[ModIdx]) begin
      cd1_q   <= check_digit_f(sum1_q);
      cd2_q   <= check_digit_f(sum2_q);
      m_d9_q  <= s_d9_q;
      m_d10_q <= s_d10_q;
      m_bad_q <= s_bad_q;
    end
  end

  // ---------------------------------------------------------------------
  // Output stage: compare, first failure wins
  // ---------------------------------------------------------------------
  status_e status_d, status_q;

  always_comb begin
    if (m_bad_q) begin
      status_d = ST_RANGE;
    end else if (cd1_q != m_d9_q) begin
      status_d = ST_FIRST;
    end else if (cd2_q != m_d10_q) begin
      status_d = ST_SECOND;
    end else begin
      status_d = ST_VALID;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[Last]) begin
      status_q <= status_d;
    end
  end

  assign status_o   = status_q;
  assign is_valid_o = (status_q == ST_VALID);

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  // Input back-pressure only arises from a stalled, full pipeline
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i && (&v_q)))
    else $error("input stalled with a free stage");

  // An accepted transfer occupies the input stage on the next cycle
  a_in_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> v_q[0])
    else $error("accepted transfer lost at input stage");

  // A stalled result keeps its verdict
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(status_q)))
    else $error("stalled result changed");

endmodule

FILE: dv/cpf_verdict_checker.sv
`timescale 1ns / 100ps
// Result checker for the CPF check-digit validator: watches both channels,
// predicts the verdict for every accepted number and compares it in order.
// Depends on cpfv_pkg.
module cpf_verdict_checker (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     in_ready_i,
  input  logic [cpfv_pkg::InW-1:0] cpf_number_i,
  input  logic                     out_valid_i,
  input  logic                     out_ready_i,
  input  logic                     is_valid_i,
  input  logic [1:0]               status_i,
  output int unsigned              mismatch_count_o,
  output int unsigned              outstanding_o
);
  import cpfv_pkg::*;

  localparam int unsigned CpfModulus = 11;
  localparam int unsigned DigitScale = 10;

  typedef int unsigned digit_row_t [NumDigits];

  typedef struct packed {
    logic    is_valid;
    status_e status;
  } verdict_t;

  verdict_t expected_verdicts[$];

  initial begin
    mismatch_count_o = 0;
    outstanding_o    = 0;
  end

  // Check digit over the first count digits, weights count+1 down to 2
  function automatic int unsigned mod11_digit(digit_row_t dig, int unsigned count);
    int unsigned acc;
    acc = 0;
    for (int unsigned k = 0; k < count; k++) acc += dig[k] * (count + 1 - k);
    acc = (DigitScale * acc) % CpfModulus;
    if (acc >= DigitScale) acc = 0;
    return acc;
  endfunction

  // Verdict for one number; the first check digit is judged before the second
  function automatic verdict_t predict_verdict(logic [InW-1:0] number);
    longint unsigned rest;
    digit_row_t      dig;
    verdict_t        v;
    v.is_valid = 1'b0;
    v.status   = ST_RANGE;
    if (number != '0 && number <= CpfMax) begin
      rest = 64'(number);
      for (int k = NumDigits - 1; k >= 0; k--) begin
        dig[k] = int'(rest % 64'd10);
        rest   = rest / 64'd10;
      end
      if (mod11_digit(dig, NumDigits - 2) != dig[NumDigits-2]) begin
        v.status = ST_FIRST;
      end else if (mod11_digit(dig, NumDigits - 1) != dig[NumDigits-1]) begin
        v.status = ST_SECOND;
      end else begin
        v.status   = ST_VALID;
        v.is_valid = 1'b1;
      end
    end
    return v;
  endfunction

  // Compare each output transfer with the oldest prediction, then queue new ones
  always @(posedge clk_i) begin : watch
    verdict_t want;
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        if (expected_verdicts.size() == 0) begin
          $error("unexpected result: is_valid %0b status %0d", is_valid_i, status_i);
          mismatch_count_o++;
        end else begin
          want = expected_verdicts.pop_front();
          if (is_valid_i !== want.is_valid) begin
            $error("is_valid: expected %0b, got %0b", want.is_valid, is_valid_i);
            mismatch_count_o++;
          end
          if (status_i !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_i);
            mismatch_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) expected_verdicts.push_back(predict_verdict(cpf_number_i));
      outstanding_o = expected_verdicts.size();
    end
  end

endmodule

FILE: dv/cpf_check_digit_validator_unit_tb.sv
`timescale 1ns / 100ps
// Testbench top for the CPF check-digit validator: clock, reset, number
// stimulus, output back-pressure and the final verdict.
// Depends on cpfv_pkg, cpf_check_digit_validator_unit and cpf_verdict_checker.
module cpf_check_digit_validator_unit_tb;
  import cpfv_pkg::*;

  localparam int unsigned  RandomCount = 500;
  localparam int unsigned  DrainCycles = 30;
  localparam int unsigned  HoldStart   = 300;
  localparam int unsigned  HoldCycles  = 80;
  localparam longint unsigned CpfTop   = 64'd99999999999;
  localparam longint unsigned InSpan   = 64'd1 << InW;

  logic           clk_i        = 1'b0;
  logic           rst_ni       = 1'b0;
  logic           in_valid_i   = 1'b0;
  logic           in_ready_o;
  logic [InW-1:0] cpf_number_i = '0;
  logic           out_valid_o;
  logic           out_ready_i  = 1'b0;
  logic           is_valid_o;
  logic [1:0]     status_o;
  int unsigned    mismatch_count;
  int unsigned    outstanding;

  cpf_check_digit_validator_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cpf_number_i(cpf_number_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .is_valid_o  (is_valid_o),
    .status_o    (status_o)
  );

  cpf_verdict_checker u_verdict_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .cpf_number_i    (cpf_number_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .is_valid_i      (is_valid_o),
    .status_i        (status_o),
    .mismatch_count_o(mismatch_count),
    .outstanding_o   (outstanding)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  // Builds a well-formed CPF from its nine leading digits
  function automatic longint unsigned make_cpf(longint unsigned base);
    int unsigned dig[9];
    int unsigned s1, s2, c1, c2;
    s1 = 0;
    s2 = 0;
    for (int k = 8; k >= 0; k--) begin
      dig[k] = int'(base % 64'd10);
      base   = base / 64'd10;
    end
    for (int k = 0; k < 9; k++) begin
      s1 += dig[k] * (10 - k);
      s2 += dig[k] * (11 - k);
    end
    c1 = (10 * s1) % 11;
    if (c1 >= 10) c1 = 0;
    s2 += 2 * c1;
    c2 = (10 * s2) % 11;
    if (c2 >= 10) c2 = 0;
    for (int k = 0; k < 9; k++) base = base * 64'd10 + dig[k];
    return base * 64'd100 + c1 * 10 + c2;
  endfunction

  // Shifts either or both check digits of a number to another digit
  function automatic longint unsigned spoil_cpf(longint unsigned v, bit first, bit second);
    longint unsigned d9, d10;
    d9  = (v / 64'd10) % 64'd10;
    d10 = v % 64'd10;
    if (first) d9 = (d9 + $urandom_range(1, 9)) % 64'd10;
    if (second) d10 = (d10 + $urandom_range(1, 9)) % 64'd10;
    return (v / 64'd100) * 64'd100 + d9 * 64'd10 + d10;
  endfunction

  // Random number: half well-formed, the rest spoiled, out of range or raw
  function automatic longint unsigned random_cpf();
    int unsigned     pick;
    longint unsigned base;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 9) == 0) base = $urandom_range(0, 999);
    else base = $urandom_range(0, 999999999);
    if (pick < 50) return make_cpf(base);
    if (pick < 65) return spoil_cpf(make_cpf(base), 1'b1, 1'b0);
    if (pick < 80) return spoil_cpf(make_cpf(base), 1'b0, 1'b1);
    if (pick < 88) return spoil_cpf(make_cpf(base), 1'b1, 1'b1);
    if (pick < 93) return CpfTop + 64'd1 + ({$urandom, $urandom} % (InSpan - CpfTop - 64'd1));
    return {$urandom, $urandom} % InSpan;
  endfunction

  // One input transfer; called and left at a falling edge
  task automatic send_cpf(input longint unsigned value);
    in_valid_i   <= 1'b1;
    cpf_number_i <= value[InW-1:0];
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  // Sender gap with junk on the data lines
  task automatic idle_input(input int unsigned cycles);
    in_valid_i   <= 1'b0;
    cpf_number_i <= InW'({$urandom, $urandom});
    repeat (cycles) @(negedge clk_i);
  endtask

  // Receiver: changing stall patterns plus one long hold-off
  initial begin : drive_out_ready
    int unsigned cyc;
    int unsigned mode;
    int unsigned left;
    cyc  = 0;
    mode = 0;
    left = 0;
    forever begin
      @(negedge clk_i);
      cyc++;
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(10, 60);
      end
      left--;
      if (cyc >= HoldStart && cyc < HoldStart + HoldCycles) out_ready_i <= 1'b0;
      else case (mode)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= $urandom_range(0, 1);
        2: out_ready_i <= ($urandom_range(0, 3) == 0);
        default: out_ready_i <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // Stimulus, drain and verdict
  initial begin : drive_cpf
    longint unsigned directed[$];
    int unsigned     burst_left;
    @(posedge rst_ni);
    @(negedge clk_i);

    // Zero, range edges, all ones, leading zeros, check digit of ten, bad digits
    directed = '{64'd0, 64'd1, CpfTop, CpfTop + 64'd1, InSpan - 64'd1,
                 64'd11144477735, 64'd11111111111, 64'd10000000000,
                 make_cpf(64'd6), make_cpf(64'd12345), make_cpf(64'd100000000),
                 make_cpf(64'd999999999), 64'd99999999998, 64'd99999999989,
                 spoil_cpf(make_cpf(64'd123456789), 1'b1, 1'b0),
                 spoil_cpf(make_cpf(64'd123456789), 1'b0, 1'b1),
                 spoil_cpf(make_cpf(64'd123456789), 1'b1, 1'b1),
                 64'd191, 64'd98765432100, 64'd68719476736};
    foreach (directed[i]) begin
      send_cpf(directed[i]);
      if ($urandom_range(0, 3) == 0) idle_input($urandom_range(1, 3));
    end

    burst_left = 0;
    for (int unsigned n = 0; n < RandomCount; n++) begin
      if (burst_left == 0) begin
        idle_input($urandom_range(1, 8));
        burst_left = $urandom_range(1, 24);
      end
      send_cpf(random_cpf());
      burst_left--;
    end
    in_valid_i <= 1'b0;

    while (outstanding != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("cpf_check_digit_validator_unit test passed");
    end else begin
      $display("cpf_check_digit_validator_unit test failed");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #5ms;
    $display("cpf_check_digit_validator_unit test failed");
    $finish;
  end

endmodule
